// ===== src/assert_macros.svh =====
// Assertion macros used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ===== src/ddc_pkg.sv =====
// Shared constants and types for the doorway direction counter.
package ddc_pkg;

  localparam int SLOTS = 3;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MOVE_THRESHOLD = 3'd0,
    REG_MISS_LIMIT     = 3'd1,
    REG_AREA_MIN_X     = 3'd2,
    REG_AREA_MAX_X     = 3'd3,
    REG_AREA_MIN_Y     = 3'd4,
    REG_AREA_MAX_Y     = 3'd5
  } reg_index_t;

  // Request codes
  localparam logic REQ_FRAME = 1'b0;
  localparam logic REQ_CLEAR = 1'b1;

  // One radar target slot
  typedef struct packed {
    logic               valid;
    logic signed [15:0] x;
    logic signed [15:0] y;
  } slot_in_t;

  localparam logic [15:0]        CNT_MAX = 16'hFFFF;
  localparam logic signed [15:0] OCC_MAX = 16'sh7FFF;
  localparam logic signed [15:0] OCC_MIN = 16'sh8000;
  localparam logic [7:0]         MISS_MAX = 8'hFF;

endpackage

// ===== src/doorway_direction_counter.sv =====
// Top level: radar-frame doorway counter with tracking slots and counters.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one radar frame with up to
//   three target slots, or a clear request (req_type = 1). Output channel
//   (out_valid / out_stall) carries one result per input: occupancy, entry
//   and exit totals, the entries and exits counted for this item, and a
//   changed flag. A transfer happens at a clock edge with valid high and
//   stall low.
//   Each item passes the input register and then the result register before
//   its result transfers. Throughput: one item per cycle while the receiver
//   does not stall; all slot work is done in the single pass between the
//   registers. When the receiver stalls, the result register holds; the input
//   register then holds too and in_stall rises until the result is taken.
//   Reset (rst, synchronous, active high) empties both registers, clears all
//   tracking slots and counters, and restores the configuration defaults.
//   Configuration writes (cfg_we, cfg_index, cfg_data) take effect at the
//   next edge and are meant to happen only while the block is idle.
`include "assert_macros.svh"

module doorway_direction_counter
  import ddc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // configuration
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // input channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  req_type,
  input  logic [1:0]            target_count,
  input  logic                  slot0_valid,
  input  logic signed [15:0]    slot0_x,
  input  logic signed [15:0]    slot0_y,
  input  logic                  slot1_valid,
  input  logic signed [15:0]    slot1_x,
  input  logic signed [15:0]    slot1_y,
  input  logic                  slot2_valid,
  input  logic signed [15:0]    slot2_x,
  input  logic signed [15:0]    slot2_y,
  // output channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic signed [15:0]    occupancy,
  output logic [15:0]           entries_total,
  output logic [15:0]           exits_total,
  output logic [1:0]            new_entries,
  output logic [1:0]            new_exits,
  output logic                  changed
);

  // configuration registers
  logic [15:0]        move_threshold;
  logic [7:0]         miss_limit;
  logic signed [15:0] area_min_x;
  logic signed [15:0] area_max_x;
  logic signed [15:0] area_min_y;
  logic signed [15:0] area_max_y;

  // input register
  logic               s1_valid;
  logic               s1_req_type;
  logic [1:0]         s1_target_count;
  slot_in_t           s1_slot [SLOTS];
  slot_in_t           in_slot [SLOTS];

  // tracking state
  logic               slot_active [SLOTS];
  logic               slot_counted [SLOTS];
  logic signed [15:0] slot_start_x [SLOTS];
  logic [7:0]         slot_misses [SLOTS];
  logic signed [15:0] occupancy_reg;
  logic [15:0]        entries_reg;
  logic [15:0]        exits_reg;

  logic               slot_active_next [SLOTS];
  logic               slot_counted_next [SLOTS];
  logic signed [15:0] slot_start_x_next [SLOTS];
  logic [7:0]         slot_misses_next [SLOTS];
  logic signed [15:0] occupancy_next;
  logic [15:0]        entries_next;
  logic [15:0]        exits_next;
  logic [1:0]         new_entries_next;
  logic [1:0]         new_exits_next;
  logic               changed_next;

  // per-slot decisions
  logic               present [SLOTS];
  logic               move_hit [SLOTS];
  logic               move_pos [SLOTS];
  logic signed [16:0] move_d [SLOTS];
  logic [16:0]        move_mag [SLOTS];
  logic [7:0]         miss_inc [SLOTS];

  logic s1_advance;

  assign in_slot[0] = '{valid: slot0_valid, x: slot0_x, y: slot0_y};
  assign in_slot[1] = '{valid: slot1_valid, x: slot1_x, y: slot1_y};
  assign in_slot[2] = '{valid: slot2_valid, x: slot2_x, y: slot2_y};

  // Advance when the input register holds an item and the result register is empty or being drained
  assign s1_advance = s1_valid && !(out_valid && out_stall);
  assign in_stall   = s1_valid && out_valid && out_stall;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      move_threshold <= 16'd500;
      miss_limit     <= 8'd5;
      area_min_x     <= -16'sd2000;
      area_max_x     <= 16'sd2000;
      area_min_y     <= 16'sd0;
      area_max_y     <= 16'sd6000;
    end else if (cfg_we) begin
      case (reg_index_t'(cfg_index))
        REG_MOVE_THRESHOLD: move_threshold <= cfg_data;
        REG_MISS_LIMIT:     miss_limit     <= cfg_data[7:0];
        REG_AREA_MIN_X:     area_min_x     <= $signed(cfg_data);
        REG_AREA_MAX_X:     area_max_x     <= $signed(cfg_data);
        REG_AREA_MIN_Y:     area_min_y     <= $signed(cfg_data);
        REG_AREA_MAX_Y:     area_max_y     <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  // Load the input register on each input transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_req_type     <= req_type;
      s1_target_count <= target_count;
      s1_slot         <= in_slot;
    end
  end

  // Classify each slot independently
  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      present[i] = (2'(i) < s1_target_count) && s1_slot[i].valid &&
                   (s1_slot[i].x >= area_min_x) && (s1_slot[i].x <= area_max_x) &&
                   (s1_slot[i].y >= area_min_y) && (s1_slot[i].y <= area_max_y);
      move_d[i]   = {s1_slot[i].x[15], s1_slot[i].x} -
                    {slot_start_x[i][15], slot_start_x[i]};
      move_mag[i] = move_d[i][16] ? 17'(-move_d[i]) : 17'(move_d[i]);
      move_hit[i] = move_mag[i] >= {1'b0, move_threshold};
      move_pos[i] = !move_d[i][16] && (move_d[i] != 17'sd0);
      miss_inc[i] = (slot_misses[i] != MISS_MAX) ? slot_misses[i] + 8'd1 : slot_misses[i];
    end
  end

  // Update slots and counters in slot order, saturating each step, or clear them on a clear request
  always_comb begin
    occupancy_next   = occupancy_reg;
    entries_next     = entries_reg;
    exits_next       = exits_reg;
    new_entries_next = 2'd0;
    new_exits_next   = 2'd0;
    changed_next     = 1'b0;
    slot_active_next  = slot_active;
    slot_counted_next = slot_counted;
    slot_start_x_next = slot_start_x;
    slot_misses_next  = slot_misses;
    if (s1_req_type == REQ_CLEAR) begin
      occupancy_next = 16'sd0;
      entries_next   = 16'd0;
      exits_next     = 16'd0;
      changed_next   = 1'b1;
      for (int i = 0; i < SLOTS; i++) begin
        slot_active_next[i]  = 1'b0;
        slot_counted_next[i] = 1'b0;
        slot_misses_next[i]  = 8'd0;
      end
    end else begin
      for (int i = 0; i < SLOTS; i++) begin
        if (present[i]) begin
          slot_misses_next[i] = 8'd0;
          if (!slot_active[i]) begin
            slot_active_next[i]  = 1'b1;
            slot_start_x_next[i] = s1_slot[i].x;
            slot_counted_next[i] = 1'b0;
          end else if (!slot_counted[i] && move_hit[i]) begin
            slot_counted_next[i] = 1'b1;
            changed_next         = 1'b1;
            if (move_pos[i]) begin
              if (entries_next != CNT_MAX) entries_next = entries_next + 16'd1;
              if (occupancy_next != OCC_MAX) occupancy_next = occupancy_next + 16'sd1;
              new_entries_next = new_entries_next + 2'd1;
            end else begin
              if (exits_next != CNT_MAX) exits_next = exits_next + 16'd1;
              if (occupancy_next != OCC_MIN) occupancy_next = occupancy_next - 16'sd1;
              new_exits_next = new_exits_next + 2'd1;
            end
          end
        end else if (slot_active[i]) begin
          slot_misses_next[i] = miss_inc[i];
          if (miss_inc[i] >= miss_limit) slot_active_next[i] = 1'b0;
        end
      end
    end
  end

  // Hold tracking state; update on each advance
  always_ff @(posedge clk) begin
    if (rst) begin
      occupancy_reg <= 16'sd0;
      entries_reg   <= 16'd0;
      exits_reg     <= 16'd0;
      for (int i = 0; i < SLOTS; i++) begin
        slot_active[i]  <= 1'b0;
        slot_counted[i] <= 1'b0;
        slot_misses[i]  <= 8'd0;
      end
    end else if (s1_advance) begin
      occupancy_reg <= occupancy_next;
      entries_reg   <= entries_next;
      exits_reg     <= exits_next;
      slot_active   <= slot_active_next;
      slot_counted  <= slot_counted_next;
      slot_misses   <= slot_misses_next;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      slot_start_x <= slot_start_x_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!(out_valid && out_stall)) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      occupancy     <= occupancy_next;
      entries_total <= entries_next;
      exits_total   <= exits_next;
      new_entries   <= new_entries_next;
      new_exits     <= new_exits_next;
      changed       <= changed_next;
    end
  end

  // Checks
  `ASSERT_IMPLY(a_counts_flag_change, clk, rst,
    out_valid && (new_entries != 2'd0 || new_exits != 2'd0), changed)
  `ASSERT_IMPLY(a_stall_only_when_blocked, clk, rst, in_stall, out_valid && out_stall)
  `ASSERT_NEXT(a_clear_zeroes, clk, rst, s1_advance && s1_req_type == REQ_CLEAR,
    entries_reg == 16'd0 && exits_reg == 16'd0 && occupancy_reg == 16'sd0)
  `ASSERT_NEXT(a_result_tracks_state, clk, rst, s1_advance,
    entries_total == entries_reg && exits_total == exits_reg)

endmodule

// ===== verif/ddc_tally_checker.sv =====
// Checker for the doorway counter: tracks passages per frame and compares every result.
module ddc_tally_checker
  import ddc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  logic                  req_type,
  input  logic [1:0]            target_count,
  input  logic                  slot0_valid,
  input  logic signed [15:0]    slot0_x,
  input  logic signed [15:0]    slot0_y,
  input  logic                  slot1_valid,
  input  logic signed [15:0]    slot1_x,
  input  logic signed [15:0]    slot1_y,
  input  logic                  slot2_valid,
  input  logic signed [15:0]    slot2_x,
  input  logic signed [15:0]    slot2_y,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  logic signed [15:0]    occupancy,
  input  logic [15:0]           entries_total,
  input  logic [15:0]           exits_total,
  input  logic [1:0]            new_entries,
  input  logic [1:0]            new_exits,
  input  logic                  changed,
  output int                    fail_count,
  output int                    pending
);

  typedef struct packed {
    logic signed [15:0] occ;
    logic [15:0]        ent;
    logic [15:0]        ext;
    logic [1:0]         n_in;
    logic [1:0]         n_out;
    logic               chg;
  } tally_t;

  localparam logic [15:0]        TOTAL_TOP = 16'hFFFF;
  localparam logic signed [15:0] OCC_TOP   = 16'sh7FFF;
  localparam logic signed [15:0] OCC_FLOOR = 16'sh8000;
  localparam logic [7:0]         MISS_TOP  = 8'hFF;

  // Configuration copy
  logic [15:0]        move_thr;
  logic [7:0]         miss_lim;
  logic signed [15:0] min_x, max_x, min_y, max_y;

  // Tracking state
  logic               active  [SLOTS];
  logic               counted [SLOTS];
  logic signed [15:0] start_x [SLOTS];
  logic [7:0]         misses  [SLOTS];
  logic signed [15:0] occ_now;
  logic [15:0]        entries_now;
  logic [15:0]        exits_now;

  tally_t expected_tallies [$];

  initial fail_count = 0;
  initial pending = 0;

  function automatic void clear_tracks();
    for (int k = 0; k < SLOTS; k++) begin
      active[k] = 1'b0;
      counted[k] = 1'b0;
      start_x[k] = '0;
      misses[k] = '0;
    end
    occ_now = '0;
    entries_now = '0;
    exits_now = '0;
  endfunction

  // Advance the tracks by one frame and return the counters it leaves
  function automatic tally_t track_frame(logic req, logic [1:0] tcount,
                                         slot_in_t s [SLOTS]);
    tally_t             t;
    logic               present;
    logic signed [15:0] px, py;
    logic signed [16:0] move;
    logic [16:0]        mag;
    t = '0;
    if (req == REQ_CLEAR) begin
      clear_tracks();
      t.chg = 1'b1;
    end else begin
      for (int k = 0; k < SLOTS; k++) begin
        px = $signed(s[k].x);
        py = $signed(s[k].y);
        present = (k < tcount) && s[k].valid && px >= min_x && px <= max_x &&
                  py >= min_y && py <= max_y;
        if (present) begin
          if (!active[k]) begin
            // acquire: remember where the target started
            active[k] = 1'b1;
            start_x[k] = px;
            counted[k] = 1'b0;
            misses[k] = '0;
          end else begin
            misses[k] = '0;
            if (!counted[k]) begin
              move = $signed({px[15], px}) - $signed({start_x[k][15], start_x[k]});
              mag = move[16] ? 17'(-move) : 17'(move);
              if (mag >= {1'b0, move_thr}) begin
                if (!move[16] && move != 17'sd0) begin
                  if (entries_now != TOTAL_TOP) entries_now = entries_now + 16'd1;
                  if (occ_now != OCC_TOP) occ_now = occ_now + 16'sd1;
                  t.n_in = t.n_in + 2'd1;
                end else begin
                  if (exits_now != TOTAL_TOP) exits_now = exits_now + 16'd1;
                  if (occ_now != OCC_FLOOR) occ_now = occ_now - 16'sd1;
                  t.n_out = t.n_out + 2'd1;
                end
                counted[k] = 1'b1;
                t.chg = 1'b1;
              end
            end
          end
        end else if (active[k]) begin
          // count the miss and drop the track at the limit
          if (misses[k] != MISS_TOP) misses[k] = misses[k] + 8'd1;
          if (misses[k] >= miss_lim) active[k] = 1'b0;
        end
      end
    end
    t.occ = occ_now;
    t.ent = entries_now;
    t.ext = exits_now;
    return t;
  endfunction

  task automatic check_field(string field, logic [15:0] want, logic [15:0] got, bit sgn);
    if (got !== want) begin
      if (sgn) $error("%s: expected %0d, got %0d", field, $signed(want), $signed(got));
      else $error("%s: expected %0d, got %0d", field, want, got);
      fail_count++;
    end
  endtask

  // Watch the configuration port and both channels
  always @(posedge clk) begin : watch
    slot_in_t seen [SLOTS];
    tally_t   want;
    seen[0] = {slot0_valid, slot0_x, slot0_y};
    seen[1] = {slot1_valid, slot1_x, slot1_y};
    seen[2] = {slot2_valid, slot2_x, slot2_y};
    if (rst) begin
      move_thr = 16'd500;
      miss_lim = 8'd5;
      min_x = -16'sd2000;
      max_x = 16'sd2000;
      min_y = 16'sd0;
      max_y = 16'sd6000;
      clear_tracks();
      expected_tallies.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_MOVE_THRESHOLD: move_thr = cfg_data;
          REG_MISS_LIMIT:     miss_lim = cfg_data[7:0];
          REG_AREA_MIN_X:     min_x = $signed(cfg_data);
          REG_AREA_MAX_X:     max_x = $signed(cfg_data);
          REG_AREA_MIN_Y:     min_y = $signed(cfg_data);
          REG_AREA_MAX_Y:     max_y = $signed(cfg_data);
          default: ;
        endcase
      end
      // compare the result transfer with the oldest prediction
      if (out_valid && !out_stall) begin
        if (expected_tallies.size() == 0) begin
          $error("result transfer with no prediction waiting");
          fail_count++;
        end else begin
          want = expected_tallies.pop_front();
          check_field("occupancy", want.occ, occupancy, 1'b1);
          check_field("entries_total", want.ent, entries_total, 1'b0);
          check_field("exits_total", want.ext, exits_total, 1'b0);
          check_field("new_entries", want.n_in, new_entries, 1'b0);
          check_field("new_exits", want.n_out, new_exits, 1'b0);
          check_field("changed", want.chg, changed, 1'b0);
        end
      end
      if (in_valid && !in_stall)
        expected_tallies.push_back(track_frame(req_type, target_count, seen));
    end
    pending = expected_tallies.size();
  end

endmodule

// ===== verif/tb_top.sv =====
// Testbench top: drives frames and configuration into the doorway counter and gives the verdict.
module tb_top;
  import ddc_pkg::*;

  localparam int LATENCY     = 2;
  localparam int IDLE_LIMIT  = 3000;
  localparam int PHASE_ITEMS = 170;
  localparam int PUMP_FRAMES = 40;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  req_type = REQ_FRAME;
  logic [1:0]            target_count = '0;
  logic                  slot0_valid = 1'b0;
  logic signed [15:0]    slot0_x = '0;
  logic signed [15:0]    slot0_y = '0;
  logic                  slot1_valid = 1'b0;
  logic signed [15:0]    slot1_x = '0;
  logic signed [15:0]    slot1_y = '0;
  logic                  slot2_valid = 1'b0;
  logic signed [15:0]    slot2_x = '0;
  logic signed [15:0]    slot2_y = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic signed [15:0]    occupancy;
  logic [15:0]           entries_total;
  logic [15:0]           exits_total;
  logic [1:0]            new_entries;
  logic [1:0]            new_exits;
  logic                  changed;
  int                    fail_count;
  int                    pending;

  // Stimulus state
  slot_in_t stage [SLOTS];
  bit       calm = 1'b0;
  int       stall_left = 0;
  int       idle_run = 0;
  bit       walk_on [SLOTS];
  int       walk_x [SLOTS];
  int       walk_y [SLOTS];
  int       walk_step [SLOTS];
  int       lo_x = -2000, hi_x = 2000, lo_y = 0, hi_y = 6000;

  doorway_direction_counter dut (.*);
  ddc_tally_checker tally_check (.*);

  always #6 clk = ~clk;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 50);
  endfunction

  function automatic logic signed [15:0] rand_mm();
    logic [31:0] r;
    r = $urandom;
    return r[15:0];
  endfunction

  function automatic logic signed [15:0] clamp16(int v);
    if (v > 32767) return 16'sh7FFF;
    if (v < -32768) return 16'sh8000;
    return v[15:0];
  endfunction

  function automatic int pick_in(int lo, int hi);
    if (hi < lo) return int'(rand_mm());
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  // Stall the result side in bursts; no new burst starts while calm
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (calm || $urandom_range(0, 2) != 0) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= 1'b1;
      stall_left <= pick_gap();
    end
  end

  // End the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_run <= 0;
    else idle_run <= idle_run + 1;
    if (idle_run >= IDLE_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  task automatic blank();
    for (int k = 0; k < SLOTS; k++) stage[k] = '{1'b0, 16'sd0, 16'sd0};
  endtask

  task automatic put(int k, bit v, int x, int y);
    stage[k] = '{v, x[15:0], y[15:0]};
  endtask

  // Present one item after a random gap and hold it until the transfer
  task automatic send_frame(logic rq, logic [1:0] tc);
    int gap;
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= rq;
    target_count <= tc;
    slot0_valid <= stage[0].valid;
    slot0_x <= stage[0].x;
    slot0_y <= stage[0].y;
    slot1_valid <= stage[1].valid;
    slot1_x <= stage[1].x;
    slot1_y <= stage[1].y;
    slot2_valid <= stage[2].valid;
    slot2_x <= stage[2].x;
    slot2_y <= stage[2].y;
    do @(posedge clk); while (in_stall !== 1'b0);
  endtask

  task automatic frame3();
    send_frame(REQ_FRAME, 2'd3);
  endtask

  // Hold off the sender until every result has come back
  task automatic settle();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  task automatic cfg_put(reg_index_t idx, int v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v[15:0];
    @(posedge clk);
  endtask

  task automatic load_setup(int thr, int miss, int lx, int hx, int ly, int hy);
    settle();
    cfg_put(REG_MOVE_THRESHOLD, thr);
    cfg_put(REG_MISS_LIMIT, miss);
    cfg_put(REG_AREA_MIN_X, lx);
    cfg_put(REG_AREA_MAX_X, hx);
    cfg_put(REG_AREA_MIN_Y, ly);
    cfg_put(REG_AREA_MAX_Y, hy);
    cfg_we <= 1'b0;
    lo_x = lx;
    hi_x = hx;
    lo_y = ly;
    hi_y = hy;
  endtask

  // Mostly people walking across the rectangle, the rest random noise
  task automatic build_frame(output logic rq, output logic [1:0] tc);
    int r;
    r = $urandom_range(0, 99);
    rq = REQ_FRAME;
    tc = 2'd3;
    if (r < 14) begin
      if (r < 3) rq = REQ_CLEAR;
      tc = 2'($urandom_range(0, 3));
      for (int k = 0; k < SLOTS; k++) begin
        stage[k].valid = 1'($urandom_range(0, 1));
        stage[k].x = rand_mm();
        stage[k].y = rand_mm();
      end
    end else begin
      if ($urandom_range(0, 9) == 0) tc = 2'($urandom_range(0, 3));
      for (int k = 0; k < SLOTS; k++) begin
        if (!walk_on[k] && $urandom_range(0, 3) == 0) begin
          walk_on[k] = 1'b1;
          walk_x[k] = pick_in(lo_x, hi_x);
          walk_y[k] = pick_in(lo_y, hi_y);
          walk_step[k] = $urandom_range(20, 900);
          if ($urandom_range(0, 1)) walk_step[k] = -walk_step[k];
        end else if (walk_on[k]) begin
          walk_x[k] = walk_x[k] + walk_step[k];
        end
        if (walk_on[k]) begin
          stage[k].valid = ($urandom_range(0, 11) != 0);
          stage[k].x = clamp16(walk_x[k]);
          stage[k].y = walk_y[k][15:0];
          if (walk_x[k] < lo_x || walk_x[k] > hi_x) walk_on[k] = 1'b0;
        end else begin
          stage[k].valid = 1'($urandom_range(0, 1));
          stage[k].x = rand_mm();
          stage[k].y = rand_mm();
        end
      end
    end
  endtask

  task automatic random_phase(int items);
    logic       rq;
    logic [1:0] tc;
    for (int k = 0; k < SLOTS; k++) walk_on[k] = 1'b0;
    for (int i = 0; i < items; i++) begin
      if (i % 64 == 0) calm = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 149) == 0) settle();
      build_frame(rq, tc);
      send_frame(rq, tc);
    end
    calm = 1'b0;
  endtask

  // Staggered acquire / count / drop on all slots: one count per frame
  task automatic pump(bit up, int frames);
    for (int j = 0; j < frames; j++) begin
      for (int k = 0; k < SLOTS; k++) begin
        case ((j + k) % 3)
          0: put(k, 1'b1, 0, 0);
          1: put(k, 1'b1, up ? 1 : 0, 0);
          default: put(k, 1'b0, 0, 0);
        endcase
      end
      frame3();
    end
  endtask

  initial begin
    blank();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Reset configuration: clear ignores the frame fields
    put(0, 1, 0, 100); put(1, 1, 0, 100); put(2, 1, 0, 100);
    send_frame(REQ_CLEAR, 2'd3);
    // no slot below a zero target count
    send_frame(REQ_FRAME, 2'd0);
    // acquire on the rectangle edges
    blank(); put(0, 1, -1000, 100); put(1, 1, 1500, 6000); put(2, 1, -2000, 0); frame3();
    // move of exactly the threshold counts, one short of it does not
    blank(); put(0, 1, -500, 100); put(1, 1, 1001, 6000); put(2, 1, 2000, 0); frame3();
    blank(); put(0, 1, -2001, 100); put(1, 1, 1000, 6000); put(2, 1, 2001, 0); frame3();
    blank(); put(0, 1, 0, -1); put(1, 1, 0, 6001); put(2, 0, 0, 100); frame3();
    blank(); put(1, 1, 0, 100); put(2, 1, 0, 100); send_frame(REQ_FRAME, 2'd1);
    blank(); send_frame(REQ_FRAME, 2'd0);
    send_frame(REQ_FRAME, 2'd0);
    // re-acquire after a drop, counted slot stays quiet
    blank(); put(0, 1, 100, 100); put(1, 1, 600, 100); put(2, 1, -32768, 32767); frame3();
    blank(); put(0, 1, -400, 100); put(1, 1, 32767, -32768); frame3();

    // Zero threshold, zero miss limit, full rectangle
    load_setup(0, 0, -32768, 32767, -32768, 32767);
    send_frame(REQ_CLEAR, 2'd0);
    blank(); put(0, 1, -32768, -32768); put(1, 1, 32767, 32767); put(2, 1, 5, 0); frame3();
    blank(); put(0, 1, 32767, -32768); put(1, 1, -32768, 32767); put(2, 1, 5, 0); frame3();
    blank(); send_frame(REQ_FRAME, 2'd0);
    put(0, 1, 0, 0); put(1, 1, 0, 0); put(2, 1, 0, 0); frame3();
    put(0, 1, 1, 0); put(1, 1, 1, 0); put(2, 1, 1, 0); frame3();
    send_frame(REQ_FRAME, 2'd0);
    put(0, 1, 0, 0); put(1, 1, 0, 0); put(2, 1, 0, 0); frame3();
    put(0, 1, -1, 0); put(1, 1, -1, 0); put(2, 1, -1, 0); frame3();

    // Largest threshold still met by the widest move
    load_setup(65535, 1, -32768, 32767, -32768, 32767);
    send_frame(REQ_CLEAR, 2'd3);
    blank(); put(0, 1, -32768, 0); put(1, 1, 32767, 0); frame3();
    blank(); put(0, 1, 32767, 0); put(1, 1, 32766, 0); frame3();

    // Inverted rectangle: nothing is present
    load_setup(500, 5, 100, -100, 0, 6000);
    blank(); put(0, 1, 0, 100); put(1, 1, 100, 100); put(2, 1, -100, 100); frame3();

    // Largest miss limit: a track survives 254 misses, not 255
    load_setup(500, 255, -2000, 2000, 0, 6000);
    send_frame(REQ_CLEAR, 2'd3);
    blank(); put(0, 1, 0, 100); frame3();
    blank();
    repeat (254) frame3();
    put(0, 1, 600, 100); frame3();
    blank();
    repeat (255) frame3();
    put(0, 1, 1200, 100); frame3();
    put(0, 1, 0, 100); frame3();

    // Random traffic under several settings
    load_setup(500, 5, -2000, 2000, 0, 6000);
    random_phase(PHASE_ITEMS);
    load_setup($urandom_range(0, 1200), $urandom_range(0, 8), -int'($urandom_range(0, 8000)),
               $urandom_range(0, 8000), -int'($urandom_range(0, 1000)),
               $urandom_range(2000, 9000));
    random_phase(PHASE_ITEMS);
    load_setup(0, 0, -32768, 32767, -32768, 32767);
    random_phase(PHASE_ITEMS);
    load_setup(300, 3, $urandom_range(1, 3000), -int'($urandom_range(0, 3000)), 0, 6000);
    random_phase(PHASE_ITEMS / 4);
    load_setup($urandom_range(100, 2000), $urandom_range(1, 20), -3000, 3000,
               -int'($urandom_range(0, 500)), $urandom_range(1000, 7000));
    random_phase(PHASE_ITEMS);

    // Count exits, then entries, then exits again, one per frame with no gaps
    load_setup(0, 0, -32768, 32767, -32768, 32767);
    send_frame(REQ_CLEAR, 2'd3);
    calm = 1'b1;
    pump(1'b0, PUMP_FRAMES);
    pump(1'b1, PUMP_FRAMES);
    pump(1'b0, 8);
    calm = 1'b0;

    settle();
    if (fail_count == 0 && pending == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

// ===== doorway_direction_counter.f =====
+incdir+src
src/ddc_pkg.sv
src/doorway_direction_counter.sv
verif/ddc_tally_checker.sv
verif/tb_top.sv
